// ----- hdl/rrct_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin completion times: shared package
// Widths, reset values and the sequencer state type of the block.
// ----------------------------------------------------------------------------
package rrct_pkg;

  localparam int DEF_MAX_PROCESSES = 16;
  localparam int BURST_BITS        = 16;
  localparam int QUANTUM_BITS      = 16;
  localparam int INDEX_BITS        = 4;
  localparam int TIME_OUT_BITS     = 20;
  localparam int TOTAL_BITS        = 24;

  localparam logic [QUANTUM_BITS-1:0] QUANTUM_RESET = QUANTUM_BITS'(4);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SIM_RD,
    ST_SIM_EX,
    ST_OUT_RD,
    ST_OUT_CALC,
    ST_OUT_HOLD
  } state_t;

endpackage

// ----- hdl/rrct_ram.sv -----
// ----------------------------------------------------------------------------
// Round-robin completion times: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/round_robin_completion_times_unit.sv -----
// ----------------------------------------------------------------------------
// Round-robin completion times unit
// Loads burst times, simulates round-robin service with a programmable
// quantum and reports end, waiting and turnaround times per process.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Word
//  -------   ---------------------  ---------------------------------------
//  input     in_valid / in_stall    burst_time, last_process
//  output    out_valid / out_stall  process_index, end_time, waiting_time,
//                                   turnaround_time, total_waiting,
//                                   total_turnaround, elapsed_total,
//                                   last_result
//  config    cfg_valid / cfg_ready  cfg_quantum
//
//  Loading accepts one word per cycle. After the last word the simulation
//  visits every stored entry once per round, each visit a RAM read
//  (ST_SIM_RD), then one subtract/compare and one clock add (ST_SIM_EX),
//  for ceil(max burst / quantum) rounds, and at least one. Each result
//  passes ST_OUT_RD, ST_OUT_CALC and ST_OUT_HOLD, held by output stalls.
//  Reset is synchronous and needs no clearing pass; in_stall stays high
//  from the last word until the final result has been taken.
//
module round_robin_completion_times_unit #(
  parameter int MAX_PROCESSES = rrct_pkg::DEF_MAX_PROCESSES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rrct_pkg::QUANTUM_BITS-1:0]  cfg_quantum,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rrct_pkg::BURST_BITS-1:0]    burst_time,
  input  logic                               last_process,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rrct_pkg::INDEX_BITS-1:0]    process_index,
  output logic [rrct_pkg::TIME_OUT_BITS-1:0] end_time,
  output logic [rrct_pkg::TIME_OUT_BITS-1:0] waiting_time,
  output logic [rrct_pkg::TIME_OUT_BITS-1:0] turnaround_time,
  output logic [rrct_pkg::TOTAL_BITS-1:0]    total_waiting,
  output logic [rrct_pkg::TOTAL_BITS-1:0]    total_turnaround,
  output logic [rrct_pkg::TIME_OUT_BITS-1:0] elapsed_total,
  output logic                               last_result
);

  import rrct_pkg::*;

  localparam int IDX_BITS  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_BITS  = $clog2(MAX_PROCESSES + 1);
  // The total of all bursts never exceeds MAX_PROCESSES full bursts.
  localparam int TIME_BITS = BURST_BITS + $clog2(MAX_PROCESSES);

  state_t                  state, state_next;
  logic [QUANTUM_BITS-1:0] quantum;
  logic [CNT_BITS-1:0]     count, count_next;
  logic [IDX_BITS-1:0]     idx, idx_next;
  logic [TIME_BITS-1:0]    clock_time, clock_time_next;
  logic                    busy, busy_next;

  logic [INDEX_BITS-1:0]    process_index_next;
  logic [TIME_OUT_BITS-1:0] end_time_next, waiting_time_next, elapsed_total_next;
  logic [TOTAL_BITS-1:0]    total_waiting_next, total_turnaround_next;
  logic                     last_result_next;
  logic                     load_out, clear_totals;

  logic                  ram_we_rem, ram_we_burst, ram_we_fin;
  logic [IDX_BITS-1:0]   ram_waddr;
  logic [BURST_BITS-1:0] rem_wdata, rem_rdata, burst_rdata;
  logic [TIME_BITS-1:0]  fin_wdata, fin_rdata;

  logic                  in_accept, store_room, idx_is_last;
  logic [BURST_BITS-1:0] q_eff, slice_step, rem_left;
  logic [BURST_BITS:0]   slice_diff;
  logic                  slice_over;
  logic [TIME_BITS-1:0]  clock_after, wait_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_LOAD);
  assign out_valid = (state == ST_OUT_HOLD);
  assign turnaround_time = end_time;

  assign in_accept   = in_valid && !in_stall;
  assign store_room  = (count < CNT_BITS'(MAX_PROCESSES));
  assign idx_is_last = ((CNT_BITS'(idx) + CNT_BITS'(1)) == count);

  // Shared slice unit: one subtract decides whether the process outlives
  // the quantum, one add advances the simulated clock.
  assign q_eff       = (quantum == '0) ? BURST_BITS'(1) : BURST_BITS'(quantum);
  assign slice_diff  = {1'b0, rem_rdata} - {1'b0, q_eff};
  assign slice_over  = !slice_diff[BURST_BITS] && (slice_diff[BURST_BITS-1:0] != '0);
  assign slice_step  = slice_over ? q_eff : rem_rdata;
  assign rem_left    = slice_over ? slice_diff[BURST_BITS-1:0] : '0;
  assign clock_after = clock_time + TIME_BITS'(slice_step);

  assign wait_full = fin_rdata - TIME_BITS'(burst_rdata);

  assign ram_waddr = (state == ST_LOAD) ? count[IDX_BITS-1:0] : idx;
  assign rem_wdata = (state == ST_LOAD) ? burst_time : rem_left;
  assign fin_wdata = (state == ST_LOAD) ? '0 : clock_after;

  rrct_ram #(.WIDTH(BURST_BITS), .DEPTH(MAX_PROCESSES)) u_rem_ram (
    .clk   (clk),
    .we    (ram_we_rem),
    .waddr (ram_waddr),
    .wdata (rem_wdata),
    .raddr (idx),
    .rdata (rem_rdata)
  );

  rrct_ram #(.WIDTH(BURST_BITS), .DEPTH(MAX_PROCESSES)) u_burst_ram (
    .clk   (clk),
    .we    (ram_we_burst),
    .waddr (ram_waddr),
    .wdata (burst_time),
    .raddr (idx),
    .rdata (burst_rdata)
  );

  rrct_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_PROCESSES)) u_fin_ram (
    .clk   (clk),
    .we    (ram_we_fin),
    .waddr (ram_waddr),
    .wdata (fin_wdata),
    .raddr (idx),
    .rdata (fin_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      quantum    <= QUANTUM_RESET;
      count      <= '0;
      idx        <= '0;
      clock_time <= '0;
      busy       <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      idx        <= idx_next;
      clock_time <= clock_time_next;
      busy       <= busy_next;
      if (cfg_valid && cfg_ready) begin
        quantum <= cfg_quantum;
      end
    end
  end

  // Output word; the total registers double as running accumulators.
  always_ff @(posedge clk) begin
    if (clear_totals) begin
      total_waiting    <= '0;
      total_turnaround <= '0;
    end else if (load_out) begin
      total_waiting    <= total_waiting_next;
      total_turnaround <= total_turnaround_next;
    end
    if (load_out) begin
      process_index <= process_index_next;
      end_time      <= end_time_next;
      waiting_time  <= waiting_time_next;
      elapsed_total <= elapsed_total_next;
      last_result   <= last_result_next;
    end
  end

  always_comb begin
    state_next            = state;
    count_next            = count;
    idx_next              = idx;
    clock_time_next       = clock_time;
    busy_next             = busy;
    ram_we_rem            = 1'b0;
    ram_we_burst          = 1'b0;
    ram_we_fin            = 1'b0;
    load_out              = 1'b0;
    clear_totals          = 1'b0;
    process_index_next    = INDEX_BITS'(idx);
    end_time_next         = TIME_OUT_BITS'(fin_rdata);
    waiting_time_next     = TIME_OUT_BITS'(wait_full);
    total_waiting_next    = total_waiting + TOTAL_BITS'(wait_full);
    total_turnaround_next = total_turnaround + TOTAL_BITS'(fin_rdata);
    elapsed_total_next    = TIME_OUT_BITS'(clock_time);
    last_result_next      = idx_is_last;

    unique case (state)
      ST_LOAD: begin
        if (in_accept) begin
          if (store_room) begin
            // A zero entry in the finish store covers zero bursts.
            ram_we_rem   = 1'b1;
            ram_we_burst = 1'b1;
            ram_we_fin   = 1'b1;
            count_next   = count + CNT_BITS'(1);
          end
          if (last_process) begin
            idx_next        = '0;
            busy_next       = 1'b0;
            clock_time_next = '0;
            state_next      = ST_SIM_RD;
          end
        end
      end
      ST_SIM_RD: begin
        state_next = ST_SIM_EX;
      end
      ST_SIM_EX: begin
        if (rem_rdata != '0) begin
          ram_we_rem      = 1'b1;
          ram_we_fin      = !slice_over;
          clock_time_next = clock_after;
        end
        if (idx_is_last) begin
          idx_next = '0;
          if (busy || slice_over) begin
            busy_next  = 1'b0;
            state_next = ST_SIM_RD;
          end else begin
            clear_totals = 1'b1;
            state_next   = ST_OUT_RD;
          end
        end else begin
          idx_next   = idx + IDX_BITS'(1);
          busy_next  = busy || slice_over;
          state_next = ST_SIM_RD;
        end
      end
      ST_OUT_RD: begin
        state_next = ST_OUT_CALC;
      end
      ST_OUT_CALC: begin
        load_out   = 1'b1;
        state_next = ST_OUT_HOLD;
      end
      ST_OUT_HOLD: begin
        if (!out_stall) begin
          if (last_result) begin
            count_next      = '0;
            clock_time_next = '0;
            idx_next        = '0;
            state_next      = ST_LOAD;
          end else begin
            idx_next   = idx + IDX_BITS'(1);
            state_next = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // The block never takes a word while a result is on offer.
  a_no_load_during_output: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input accepted while a result is pending");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(MAX_PROCESSES))
    else $error("process count beyond the store depth");

  a_last_starts_sim: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_process |=> in_stall && !out_valid)
    else $error("final word did not start the simulation");

  a_batch_end_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_result |=> count == '0 && clock_time == '0)
    else $error("batch state not cleared after the final result");

  a_visit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIM_EX || state == ST_OUT_HOLD) |-> (CNT_BITS'(idx) < count))
    else $error("entry index beyond the loaded processes");

endmodule
